### rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Types and constants shared by the sound generator core, its output checker and testbench.
// ----------------------------------------------------------------------------
package psg_pkg;

    // Operation codes carried on the input channel.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PAN   = 2'd2;

    // Noise reload selection taken from the low two mode bits.
    localparam logic [1:0] NSEL_16   = 2'd0;
    localparam logic [1:0] NSEL_32   = 2'd1;
    localparam logic [1:0] NSEL_64   = 2'd2;
    localparam logic [1:0] NSEL_TONE = 2'd3;

    // Register select codes in the latched register field (channel, attenuation flag).
    localparam logic [1:0] CH_NOISE = 2'd3;

    localparam int unsigned TONES = 3;

    localparam logic [9:0]  NOISE_RELOAD_16 = 10'h010;
    localparam logic [9:0]  NOISE_RELOAD_32 = 10'h020;
    localparam logic [9:0]  NOISE_RELOAD_64 = 10'h040;
    localparam logic [15:0] LFSR_SEED       = 16'h8000;
    localparam logic [3:0]  ATTEN_SILENT    = 4'hF;
    localparam logic [7:0]  PAN_ALL_ON      = 8'hFF;
    localparam logic [2:0]  WHITE_MODE_BIT  = 3'h4;

    // Complete generator state, held as one word of the state RAM.
    typedef struct packed {
        logic [2:0]             latched;
        logic [TONES-1:0][9:0]  tone_reload;
        logic [TONES-1:0][9:0]  tone_count;
        logic [TONES-1:0]       tone_square;
        logic [TONES-1:0][3:0]  tone_atten;
        logic [9:0]             noise_count;
        logic [2:0]             noise_mode;
        logic [15:0]            noise_shifter;
        logic                   noise_phase;
        logic                   noise_bit;
        logic [3:0]             noise_atten;
        logic [7:0]             panning;
    } psg_state_t;

    localparam psg_state_t PSG_RESET_STATE = '{
        latched:       3'd0,
        tone_reload:   '0,
        tone_count:    '0,
        tone_square:   '0,
        tone_atten:    {TONES{ATTEN_SILENT}},
        noise_count:   10'd0,
        noise_mode:    3'd0,
        noise_shifter: LFSR_SEED,
        noise_phase:   1'b0,
        noise_bit:     1'b0,
        noise_atten:   ATTEN_SILENT,
        panning:       PAN_ALL_ON
    };

endpackage

### rtl/psg_ram.sv
// ----------------------------------------------------------------------------
// psg_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module psg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a read that meets a write returns the old word.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_generator
// Pipeline: state RAM read, compute stage, then the output register.
// Throughput: one item per cycle while the output is not stalled; the
// read-modify-write of the state word forwards the last written state, so
// items may arrive back to back.
// Reset: all state reads as its reset value until the first item is written
// back; no clearing pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] tone_levels,
    output logic       noise_level,
    output logic [3:0] tone0_atten,
    output logic [3:0] tone1_atten,
    output logic [3:0] tone2_atten,
    output logic [3:0] noise_atten,
    output logic [7:0] pan_enables
);
    import psg_pkg::*;

    localparam int unsigned STATE_W = $bits(psg_state_t);

    logic             in_accept;
    logic             out_load;
    logic             commit;
    logic             s1_valid_reg;
    logic [1:0]       s1_op_reg;
    logic [7:0]       s1_data_reg;
    logic             fwd_sel_reg;
    logic             read_ok_reg;
    logic             mem_written_reg;
    psg_state_t       fwd_reg;
    logic [STATE_W-1:0] ram_rdata;
    psg_state_t       cur_state;
    psg_state_t       state_next;
    logic             out_valid_reg;
    psg_state_t       out_reg;

    // Pipeline handshake: the compute stage moves on whenever the output
    // register is empty or its result is being taken.
    assign out_load  = !out_valid_reg || !out_stall;
    assign commit    = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    // State RAM holding the single generator state word.
    psg_ram #(
        .WIDTH (STATE_W),
        .DEPTH (1)
    ) u_state_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (1'b0),
        .wdata (state_next),
        .re    (in_accept),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    // Compute stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_sel_reg     <= 1'b0;
            read_ok_reg     <= 1'b0;
            mem_written_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_sel_reg  <= commit;
                read_ok_reg  <= mem_written_reg;
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                mem_written_reg <= 1'b1;
            end
        end
    end

    // Compute stage payload and the forwarded copy of the last written state.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= operation;
            s1_data_reg <= data_byte;
        end
        if (commit)
        begin
            fwd_reg <= state_next;
        end
    end

    // Source state: a write-back in the same cycle as the read wins over the
    // RAM word, and a never-written RAM reads as the reset state.
    always_comb
    begin
        if (fwd_sel_reg)
        begin
            cur_state = fwd_reg;
        end
        else if (read_ok_reg)
        begin
            cur_state = psg_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = PSG_RESET_STATE;
        end
    end

    // Next state for the item in the compute stage.
    always_comb
    begin
        logic [9:0]  dec;
        logic        expire;
        logic        fb;
        logic [2:0]  lat;
        logic [1:0]  ch;

        state_next = cur_state;
        dec        = '0;
        expire     = 1'b0;
        fb         = 1'b0;
        lat        = cur_state.latched;
        ch         = lat[2:1];

        case (s1_op_reg)
            OP_TICK:
            begin
                // Tone timers: expire at zero or when the decrement reaches zero.
                for (int i = 0; i < TONES; i++)
                begin
                    dec    = cur_state.tone_count[i] - 10'd1;
                    expire = (cur_state.tone_count[i] == 10'd0) || (dec == 10'd0);
                    if (expire)
                    begin
                        state_next.tone_square[i] = !cur_state.tone_square[i];
                        state_next.tone_count[i]  = cur_state.tone_reload[i];
                    end
                    else
                    begin
                        state_next.tone_count[i] = dec;
                    end
                end

                // Noise timer and the shift register on every second expiry.
                dec    = cur_state.noise_count - 10'd1;
                expire = (cur_state.noise_count == 10'd0) || (dec == 10'd0);
                if (expire)
                begin
                    state_next.noise_phase = !cur_state.noise_phase;
                    case (cur_state.noise_mode[1:0])
                        NSEL_16:   state_next.noise_count = NOISE_RELOAD_16;
                        NSEL_32:   state_next.noise_count = NOISE_RELOAD_32;
                        NSEL_64:   state_next.noise_count = NOISE_RELOAD_64;
                        NSEL_TONE: state_next.noise_count = cur_state.tone_reload[TONES-1];
                        default:   state_next.noise_count = NOISE_RELOAD_16;
                    endcase
                    if (!cur_state.noise_phase)
                    begin
                        fb = cur_state.noise_shifter[0]
                           ^ (|(cur_state.noise_mode & WHITE_MODE_BIT)
                              & cur_state.noise_shifter[3]);
                        state_next.noise_shifter = {fb, cur_state.noise_shifter[15:1]};
                        state_next.noise_bit     = cur_state.noise_shifter[1];
                    end
                end
                else
                begin
                    state_next.noise_count = dec;
                end
            end

            OP_WRITE:
            begin
                // A byte with the top bit set latches a new register select.
                if (s1_data_reg[7])
                begin
                    lat = s1_data_reg[6:4];
                end
                ch = lat[2:1];
                state_next.latched = lat;
                if (ch != CH_NOISE)
                begin
                    if (lat[0])
                    begin
                        state_next.tone_atten[ch] = s1_data_reg[3:0];
                    end
                    else if (s1_data_reg[7])
                    begin
                        state_next.tone_reload[ch][3:0] = s1_data_reg[3:0];
                    end
                    else
                    begin
                        state_next.tone_reload[ch][9:4] = s1_data_reg[5:0];
                    end
                end
                else if (lat[0])
                begin
                    state_next.noise_atten = s1_data_reg[3:0];
                end
                else
                begin
                    state_next.noise_mode    = s1_data_reg[2:0];
                    state_next.noise_shifter = LFSR_SEED;
                end
            end

            OP_PAN:
            begin
                state_next.panning = s1_data_reg;
            end

            default:
            begin
                state_next = cur_state;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg <= state_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tone_levels = out_reg.tone_square;
    assign noise_level = out_reg.noise_bit;
    assign tone0_atten = out_reg.tone_atten[0];
    assign tone1_atten = out_reg.tone_atten[1];
    assign tone2_atten = out_reg.tone_atten[2];
    assign noise_atten = out_reg.noise_atten;
    assign pan_enables = out_reg.panning;

    // Every write-back produces a result in the next cycle.
    a_commit_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        commit |=> out_valid
    ) else $error("write-back did not produce a result");

    // An item waiting in the compute stage is not dropped.
    a_stage_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> s1_valid_reg
    ) else $error("stalled item left the compute stage");

    // Forwarding is only selected for an item that is in the compute stage.
    a_fwd_with_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        fwd_sel_reg && !s1_valid_reg |-> !$past(in_accept)
    ) else $error("forward select set without an item");

    // A stalled result is still presented in the next cycle.
    a_result_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid
    ) else $error("stalled result was lost");

endmodule

### verif/psg_output_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psg_output_checker
// Watches the item and result channels of the sound generator, keeps its own
// copy of the generator state, predicts one result per accepted item and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psg_output_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] tone_levels,
    input  logic       noise_level,
    input  logic [3:0] tone0_atten,
    input  logic [3:0] tone1_atten,
    input  logic [3:0] tone2_atten,
    input  logic [3:0] noise_atten,
    input  logic [7:0] pan_enables,
    output int         failures,
    output int         pending
);
    import psg_pkg::*;

    // One result as the block reports it.
    typedef struct packed {
        logic [2:0] tones;
        logic       noise;
        logic [3:0] atten0;
        logic [3:0] atten1;
        logic [3:0] atten2;
        logic [3:0] natten;
        logic [7:0] pan;
    } psg_sample_t;

    // Predicted generator state.
    logic [2:0]  sel_reg;
    logic [9:0]  period [TONES];
    logic [9:0]  count [TONES];
    logic [2:0]  square;
    logic [3:0]  atten [TONES];
    logic [9:0]  noise_count;
    logic [2:0]  noise_cfg;
    logic [15:0] lfsr;
    logic        noise_phase;
    logic        noise_out;
    logic [3:0]  noise_att;
    logic [7:0]  pan_r;

    psg_sample_t predicted_outputs [$];
    psg_sample_t want;
    psg_sample_t got;
    bit          ok;

    task automatic reset_prediction();
        sel_reg = '0;
        for (int i = 0; i < TONES; i++)
        begin
            period[i] = '0;
            count[i]  = '0;
            atten[i]  = ATTEN_SILENT;
        end
        square      = '0;
        noise_count = '0;
        noise_cfg   = '0;
        lfsr        = LFSR_SEED;
        noise_phase = 1'b0;
        noise_out   = 1'b0;
        noise_att   = ATTEN_SILENT;
        pan_r       = PAN_ALL_ON;
    endtask

    // One tick: a counter expires when it is zero or when its decrement
    // reaches zero.
    task automatic apply_tick();
        logic feedback;
        for (int i = 0; i < TONES; i++)
        begin
            if (count[i] <= 10'd1)
            begin
                square[i] = ~square[i];
                count[i]  = period[i];
            end
            else
            begin
                count[i] = count[i] - 10'd1;
            end
        end
        if (noise_count <= 10'd1)
        begin
            noise_phase = ~noise_phase;
            case (noise_cfg[1:0])
                NSEL_16: noise_count = NOISE_RELOAD_16;
                NSEL_32: noise_count = NOISE_RELOAD_32;
                NSEL_64: noise_count = NOISE_RELOAD_64;
                default: noise_count = period[2];
            endcase
            // The shifter advances on every second expiry only.
            if (noise_phase)
            begin
                feedback = lfsr[0];
                if ((noise_cfg & WHITE_MODE_BIT) != 0)
                    feedback = feedback ^ lfsr[3];
                lfsr      = {feedback, lfsr[15:1]};
                noise_out = lfsr[0];
            end
        end
        else
        begin
            noise_count = noise_count - 10'd1;
        end
    endtask

    // Latch/data byte: a latch byte selects the register, then the byte
    // is written to whichever register is latched.
    task automatic apply_byte_write(input logic [7:0] b);
        logic [1:0] chan;
        if (b[7])
            sel_reg = b[6:4];
        chan = sel_reg[2:1];
        if (chan != CH_NOISE)
        begin
            if (sel_reg[0])
                atten[chan] = b[3:0];
            else if (b[7])
                period[chan][3:0] = b[3:0];
            else
                period[chan][9:4] = b[5:0];
        end
        else if (sel_reg[0])
        begin
            noise_att = b[3:0];
        end
        else
        begin
            noise_cfg = b[2:0];
            lfsr      = LFSR_SEED;
        end
    endtask

    function automatic psg_sample_t current_outputs();
        return {square, noise_out, atten[0], atten[1], atten[2], noise_att, pan_r};
    endfunction

    function automatic bit field_ok(input string name, input logic [7:0] exp_v,
                                    input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_prediction();
            predicted_outputs.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // Result transfer: compare with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                got = {tone_levels, noise_level, tone0_atten, tone1_atten, tone2_atten,
                       noise_atten, pan_enables};
                if (predicted_outputs.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, expected none, actual %h",
                             $time, got);
                    failures <= failures + 1;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    ok = field_ok("tone_levels", 8'(want.tones), 8'(got.tones))
                       & field_ok("noise_level", 8'(want.noise), 8'(got.noise))
                       & field_ok("tone0_atten", 8'(want.atten0), 8'(got.atten0))
                       & field_ok("tone1_atten", 8'(want.atten1), 8'(got.atten1))
                       & field_ok("tone2_atten", 8'(want.atten2), 8'(got.atten2))
                       & field_ok("noise_atten", 8'(want.natten), 8'(got.natten))
                       & field_ok("pan_enables", want.pan, got.pan);
                    if (!ok)
                        failures <= failures + 1;
                end
            end
            // Item transfer: advance the predicted state and queue its result.
            if (in_valid && !in_stall)
            begin
                case (operation)
                    OP_TICK:  apply_tick();
                    OP_WRITE: apply_byte_write(data_byte);
                    OP_PAN:   pan_r = data_byte;
                    default:  ;
                endcase
                predicted_outputs.push_back(current_outputs());
            end
            pending <= predicted_outputs.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random ticks, register writes and panning writes into
// the sound generator under several idle and stall patterns, and reports the
// verdict from the failure count of the output checker.
// ----------------------------------------------------------------------------
module testbench;
    import psg_pkg::*;

    // Operation code the block leaves without effect.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 40;
    localparam int         PHASE_ITEMS = 170;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [1:0] operation   = OP_TICK;
    logic [7:0] data_byte   = '0;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [2:0] tone_levels;
    logic       noise_level;
    logic [3:0] tone0_atten;
    logic [3:0] tone1_atten;
    logic [3:0] tone2_atten;
    logic [3:0] noise_atten;
    logic [7:0] pan_enables;
    int         failures;
    int         pending;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    psg_tone_noise_generator dut (.*);

    psg_output_checker output_check (.*);

    always #5 clk = ~clk;

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            holds_served <= 0;
            hold_left    <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one item after a random gap and wait for its transfer.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
    endtask

    // Random item, biased toward short periods so that tones and noise move.
    task automatic send_random();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        b    = 8'($urandom);
        if (pick < 50)
        begin
            send_item(OP_TICK, b);
        end
        else if (pick < 85)
        begin
            if (!b[7] && $urandom_range(3) != 0)
                b[5:1] = '0;
            // Noise control restarts the shifter, so keep it less frequent.
            if (b[7] && b[6:4] == {CH_NOISE, 1'b0} && $urandom_range(1) == 0)
                b[6] = 1'b0;
            send_item(OP_WRITE, b);
        end
        else if (pick < 97)
        begin
            send_item(OP_PAN, b);
        end
        else
        begin
            send_item(OP_UNUSED, b);
        end
    endtask

    // Hold the sender back until every outstanding result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero periods, every register, extremes of the byte.
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_WRITE, 8'h8F);
        send_item(OP_WRITE, 8'h3F);
        send_item(OP_WRITE, 8'h80);
        send_item(OP_WRITE, 8'h00);
        send_item(OP_WRITE, 8'h90);
        send_item(OP_WRITE, 8'h0A);
        send_item(OP_WRITE, 8'hA3);
        send_item(OP_WRITE, 8'hB5);
        send_item(OP_WRITE, 8'hC1);
        send_item(OP_WRITE, 8'hD0);
        send_item(OP_WRITE, 8'hE7);
        send_item(OP_WRITE, 8'hF0);
        send_item(OP_WRITE, 8'h04);
        send_item(OP_WRITE, 8'hE0);
        send_item(OP_WRITE, 8'h05);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_PAN, 8'h00);
        send_item(OP_PAN, 8'hA5);
        send_item(OP_PAN, 8'hFF);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_UNUSED, 8'h00);
        drain();

        // Random part under four idle and stall patterns.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 68;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 68;
                end
                default:
                begin
                    idle_pct = 8;
                    stall_pct <= 8;
                end
            endcase
            repeat (PHASE_ITEMS) send_random();
            drain();

            // Long receiver hold-off while items keep coming back to back.
            if (phase == 0)
            begin
                hold_requests <= hold_requests + 1;
                repeat (30) send_random();
                drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### psg_tone_noise_generator.f
rtl/psg_pkg.sv
rtl/psg_ram.sv
rtl/psg_tone_noise_generator.sv
verif/psg_output_checker.sv
verif/testbench.sv
